// File: hw/rtl/hangul_bigram_counter_macros.svh
// Assertion macros shared by the hangul_bigram_counter RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef HANGUL_BIGRAM_COUNTER_MACROS_SVH
`define HANGUL_BIGRAM_COUNTER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define HBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define HBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hbc_pkg.sv
// Shared types and constants for the Hangul bigram counter.
// No dependencies; used by every RTL module of the block except hbc_ram.
package hbc_pkg;

  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [15:0] SYL_LAST   = 16'hD7A3;
  localparam logic [15:0] MARK_BEGIN = 16'h0002;
  localparam logic [15:0] MARK_END   = 16'h0001;

  // row index 0 is the begin marker, 1.. are syllables + 1
  localparam int ROW_DEPTH = 32'hD7A3 - 32'hAC00 + 2;
  localparam int SYM_W     = 14;
  localparam int CP_W      = 21;
  localparam int KEY_W     = 27;
  localparam int HASH_W    = 32;
  localparam logic [HASH_W-1:0] HASH_MUL = 32'd2654435761;

  // UTF-8 lead byte classes
  localparam logic [7:0] CONT_MASK  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2      = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3      = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4      = 8'hF0;

  typedef struct packed {
    logic [SYM_W-1:0] fi;    // 0 = begin marker
    logic [SYM_W-1:0] ti;    // 0 = end marker
    logic             last;  // final pair of this byte
  } pair_req_t;

  typedef struct packed {
    logic [15:0] from_code;
    logic [15:0] to_code;
    logic [31:0] pair_count;
    logic [31:0] row_total;
    logic        store_full;
    logic        last_of_run;
  } result_t;

endpackage

// File: hw/rtl/hbc_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/hbc_hash.sv
// Pair key hash: key multiply, golden-ratio multiply, reduction to a slot.
// Depends on hbc_pkg. Non power-of-two slot counts reduce by reciprocal multiply.
module hbc_hash #(
  parameter int PAIR_SLOTS = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hbc_pkg::SYM_W-1:0]     fi,
  input  logic [hbc_pkg::SYM_W-1:0]     ti,
  output logic                          done,
  output logic [$clog2(PAIR_SLOTS)-1:0] slot
);
  import hbc_pkg::*;

  localparam int AW      = $clog2(PAIR_SLOTS);
  localparam int RW      = AW + 1;
  localparam bit IS_POW2 = (PAIR_SLOTS & (PAIR_SLOTS - 1)) == 0;
  // floor(2^(31+AW) / PAIR_SLOTS) fits 32 bits; the quotient estimate is at
  // most one low, so one compare-subtract finishes the remainder
  localparam int QS = 31 + AW;
  localparam int QW = 64 - QS;
  localparam logic [31:0] RECIP = 32'((64'd1 << QS) / 64'(PAIR_SLOTS));

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MUL  = 5'b00010,
    H_QUO  = 5'b00100,
    H_REM  = 5'b01000,
    H_DONE = 5'b10000
  } hstate_t;

  hstate_t           st_r, st_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] hs_r;
  logic [QW-1:0]     quo_r;
  logic [RW-1:0]     rem_r;
  logic [63:0]       prod;
  logic [AW-1:0]     rem_fix;

  assign prod    = 64'(hs_r) * 64'(RECIP);
  assign rem_fix = (rem_r >= RW'(PAIR_SLOTS)) ? AW'(rem_r - RW'(PAIR_SLOTS))
                                              : rem_r[AW-1:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      H_IDLE: if (start) st_nxt = H_MUL;
      H_MUL:  st_nxt = IS_POW2 ? H_DONE : H_QUO;
      H_QUO:  st_nxt = H_REM;
      H_REM:  st_nxt = H_DONE;
      H_DONE: st_nxt = H_IDLE;
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= H_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == H_IDLE && start) begin
      key_r <= KEY_W'(fi) * KEY_W'(ROW_DEPTH) + KEY_W'(ti);
    end
    if (st_r == H_MUL) begin
      hs_r <= HASH_W'(key_r) * HASH_MUL;
    end
    if (st_r == H_QUO) begin
      quo_r <= prod[63:QS];
    end
    if (st_r == H_REM) begin
      rem_r <= RW'(hs_r - HASH_W'(quo_r) * HASH_W'(PAIR_SLOTS));
    end
  end

  assign done = (st_r == H_DONE);
  assign slot = IS_POW2 ? hs_r[AW-1:0] : rem_fix;

endmodule

// File: hw/rtl/hbc_decode.sv
// UTF-8 byte decoder and word tracker; queues up to two pair requests per byte.
// Depends on hbc_pkg and the assertion macro header.
`include "hangul_bigram_counter_macros.svh"

module hbc_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               req_valid,
  output hbc_pkg::pair_req_t req,
  input  logic               req_ready
);
  import hbc_pkg::*;

  logic [1:0]       pending_r, pending_nxt;
  logic [CP_W-1:0]  acc_r, acc_nxt;
  logic             prev_valid_r, prev_valid_nxt;
  logic [SYM_W-1:0] prev_syl_r, prev_syl_nxt;
  logic [1:0]       jcnt_r, jcnt_nxt;
  pair_req_t        job0_r, job1_r, p0, p1;

  logic             sym_v, hangul, accept;
  logic [CP_W-1:0]  cp, acc_sh;
  logic [SYM_W-1:0] off;
  logic [1:0]       n;
  logic [7:0]       cont;

  assign accept = in_valid && in_ready;
  assign cont   = text_byte & CONT_MASK;
  assign acc_sh = {acc_r[CP_W-7:0], cont[5:0]};

  always_comb begin
    pending_nxt    = pending_r;
    acc_nxt        = acc_r;
    prev_valid_nxt = prev_valid_r;
    prev_syl_nxt   = prev_syl_r;
    sym_v          = 1'b0;
    cp             = '0;
    p0             = '0;
    p1             = '0;
    n              = 2'd0;

    // byte decode
    if (pending_r != 2'd0) begin
      acc_nxt     = acc_sh;
      pending_nxt = pending_r - 2'd1;
      if (pending_r == 2'd1) begin
        sym_v = 1'b1;
        cp    = acc_sh;
      end
    end else if (!text_byte[7]) begin
      sym_v = 1'b1;
      cp    = CP_W'(text_byte);
    end else if ((text_byte & LEAD2_MASK) == LEAD2) begin
      acc_nxt     = CP_W'(text_byte & ~LEAD2_MASK);
      pending_nxt = 2'd1;
    end else if ((text_byte & LEAD3_MASK) == LEAD3) begin
      acc_nxt     = CP_W'(text_byte & ~LEAD3_MASK);
      pending_nxt = 2'd2;
    end else if ((text_byte & LEAD4_MASK) == LEAD4) begin
      acc_nxt     = CP_W'(text_byte & ~LEAD4_MASK);
      pending_nxt = 2'd3;
    end else begin
      // stray continuation or bad lead: a non-Hangul symbol
      sym_v = 1'b1;
      cp    = '1;
    end

    hangul = (cp >= CP_W'(SYL_BASE)) && (cp <= CP_W'(SYL_LAST));
    off    = SYM_W'(cp - CP_W'(SYL_BASE));

    // word tracking
    if (sym_v) begin
      if (hangul) begin
        p0.fi          = prev_valid_r ? prev_syl_r + SYM_W'(1) : '0;
        p0.ti          = off + SYM_W'(1);
        n              = 2'd1;
        prev_syl_nxt   = off;
        prev_valid_nxt = 1'b1;
      end else begin
        if (prev_valid_r) begin
          p0.fi = prev_syl_r + SYM_W'(1);
          p0.ti = '0;
          n     = 2'd1;
        end
        prev_valid_nxt = 1'b0;
      end
    end

    if (end_of_text) begin
      pending_nxt = 2'd0;
      acc_nxt     = '0;
      if (prev_valid_nxt) begin
        if (n == 2'd0) begin
          p0.fi = prev_syl_nxt + SYM_W'(1);
          p0.ti = '0;
        end else begin
          p1.fi = prev_syl_nxt + SYM_W'(1);
          p1.ti = '0;
        end
        n = n + 2'd1;
      end
      prev_valid_nxt = 1'b0;
    end

    p0.last = (n == 2'd1);
    p1.last = (n == 2'd2);
  end

  // pair queue: loaded on accept, drained one pair per engine take
  always_comb begin
    jcnt_nxt = jcnt_r;
    if (accept) begin
      jcnt_nxt = n;
    end else if (req_valid && req_ready) begin
      jcnt_nxt = jcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= '0;
      acc_r        <= '0;
      prev_valid_r <= 1'b0;
      prev_syl_r   <= '0;
      jcnt_r       <= '0;
    end else begin
      jcnt_r <= jcnt_nxt;
      if (accept) begin
        pending_r    <= pending_nxt;
        acc_r        <= acc_nxt;
        prev_valid_r <= prev_valid_nxt;
        prev_syl_r   <= prev_syl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job0_r <= p0;
      job1_r <= p1;
    end else if (req_valid && req_ready) begin
      job0_r <= job1_r;
    end
  end

  assign in_ready  = enable && (jcnt_r == 2'd0);
  assign req_valid = (jcnt_r != 2'd0);
  assign req       = job0_r;

  `HBC_ASSERT_NEXT(a_eot_flush, accept && end_of_text, pending_r == 2'd0 && !prev_valid_r, "end of text left decoder state open")
  `HBC_ASSERT_NOW(a_no_overlap, in_ready, !req_valid, "byte accepted while pairs still queued")
  `HBC_ASSERT_NEXT(a_mid_seq_quiet, accept && !end_of_text && pending_r == 2'd2, !req_valid, "pair issued inside a multibyte sequence")

endmodule

// File: hw/rtl/hbc_probe.sv
// Pair store engine: hash, linear probe, read-modify-write of pair and row RAMs.
// Depends on hbc_pkg, hbc_hash, hbc_ram and the assertion macro header.
`include "hangul_bigram_counter_macros.svh"

module hbc_probe #(
  parameter int PAIR_SLOTS = 65536,
  parameter int MAX_PROBE  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               clearing,
  input  logic               req_valid,
  output logic               req_ready,
  input  hbc_pkg::pair_req_t req,
  output logic               res_valid,
  input  logic               res_ready,
  output hbc_pkg::result_t   res
);
  import hbc_pkg::*;

  localparam int AW        = $clog2(PAIR_SLOTS);
  localparam int RAW       = $clog2(ROW_DEPTH);
  localparam int CLR_DEPTH = (PAIR_SLOTS > ROW_DEPTH) ? PAIR_SLOTS : ROW_DEPTH;
  localparam int CW        = $clog2(CLR_DEPTH);
  localparam int PW        = $clog2(MAX_PROBE + 1);

  typedef struct packed {
    logic                  valid;
    logic [SYM_W-1:0]      fi;
    logic [SYM_W-1:0]      ti;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [5:0] {
    E_CLEAR = 6'b000001,
    E_IDLE  = 6'b000010,
    E_HASH  = 6'b000100,
    E_READ  = 6'b001000,
    E_CHECK = 6'b010000,
    E_WB    = 6'b100000
  } estate_t;

  estate_t               st_r, st_nxt;
  logic [CW-1:0]         clr_r;
  logic [SYM_W-1:0]      fi_r, ti_r;
  logic                  last_r, full_r;
  logic [AW-1:0]         slot_r, slot_inc, hash_slot;
  logic [PW-1:0]         k_r;
  logic [COUNT_BITS-1:0] cnt_new_r, row_new_r, row_rdata, row_wdata;
  logic [EW-1:0]         pair_rdata, pair_wdata;
  entry_t                rd_ent, wr_ent;
  logic                  hash_done, hit, miss_last;
  logic                  pair_we, row_we, rd_en;
  logic [AW-1:0]         pair_waddr;
  logic [RAW-1:0]        row_waddr;

  hbc_hash #(.PAIR_SLOTS(PAIR_SLOTS)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == E_IDLE && req_valid),
    .fi    (req.fi),
    .ti    (req.ti),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  hbc_ram #(.WIDTH(EW), .DEPTH(PAIR_SLOTS)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (rd_en),
    .raddr (slot_r),
    .rdata (pair_rdata)
  );

  hbc_ram #(.WIDTH(COUNT_BITS), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (rd_en),
    .raddr (fi_r),
    .rdata (row_rdata)
  );

  assign rd_ent    = pair_rdata;
  assign hit       = !rd_ent.valid || (rd_ent.fi == fi_r && rd_ent.ti == ti_r);
  assign miss_last = (k_r == PW'(MAX_PROBE - 1));
  assign slot_inc  = (slot_r == AW'(PAIR_SLOTS - 1)) ? '0 : slot_r + AW'(1);
  assign rd_en     = (st_r == E_READ);

  // write port: zero sweep after reset, else write-back of a counted pair
  always_comb begin
    wr_ent.valid = 1'b1;
    wr_ent.fi    = fi_r;
    wr_ent.ti    = ti_r;
    wr_ent.cnt   = cnt_new_r;
    if (st_r == E_CLEAR) begin
      pair_we    = (32'(clr_r) < PAIR_SLOTS);
      row_we     = (32'(clr_r) < ROW_DEPTH);
      pair_waddr = clr_r[AW-1:0];
      row_waddr  = clr_r[RAW-1:0];
      pair_wdata = '0;
      row_wdata  = '0;
    end else begin
      pair_we    = (st_r == E_WB) && !full_r;
      row_we     = (st_r == E_WB) && !full_r;
      pair_waddr = slot_r;
      row_waddr  = fi_r;
      pair_wdata = wr_ent;
      row_wdata  = row_new_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      E_CLEAR: if (clr_r == CW'(CLR_DEPTH - 1)) st_nxt = E_IDLE;
      E_IDLE:  if (req_valid) st_nxt = E_HASH;
      E_HASH:  if (hash_done) st_nxt = E_READ;
      E_READ:  st_nxt = E_CHECK;
      E_CHECK: st_nxt = (hit || miss_last) ? E_WB : E_READ;
      E_WB:    if (res_ready) st_nxt = E_IDLE;
      default: st_nxt = E_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= E_CLEAR;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == E_CLEAR) begin
        clr_r <= clr_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == E_IDLE && req_valid) begin
      fi_r   <= req.fi;
      ti_r   <= req.ti;
      last_r <= req.last;
    end
    if (st_r == E_HASH && hash_done) begin
      slot_r <= hash_slot;
      k_r    <= '0;
    end
    if (st_r == E_CHECK) begin
      if (hit) begin
        if (!rd_ent.valid) begin
          cnt_new_r <= COUNT_BITS'(1);
        end else begin
          cnt_new_r <= (&rd_ent.cnt) ? rd_ent.cnt : rd_ent.cnt + COUNT_BITS'(1);
        end
        row_new_r <= (&row_rdata) ? row_rdata : row_rdata + COUNT_BITS'(1);
        full_r    <= 1'b0;
      end else if (miss_last) begin
        cnt_new_r <= '0;
        row_new_r <= row_rdata;
        full_r    <= 1'b1;
      end else begin
        k_r    <= k_r + PW'(1);
        slot_r <= slot_inc;
      end
    end
  end

  assign clearing  = (st_r == E_CLEAR);
  assign req_ready = (st_r == E_IDLE);
  assign res_valid = (st_r == E_WB);

  always_comb begin
    res.from_code   = (fi_r == '0) ? MARK_BEGIN : SYL_BASE + 16'(fi_r) - 16'd1;
    res.to_code     = (ti_r == '0) ? MARK_END : SYL_BASE + 16'(ti_r) - 16'd1;
    res.pair_count  = 32'(cnt_new_r);
    res.row_total   = 32'(row_new_r);
    res.store_full  = full_r;
    res.last_of_run = last_r;
  end

  `HBC_ASSERT_NOW(a_probe_bound, st_r == E_CHECK, k_r < PW'(MAX_PROBE), "probe ran past its limit")
  `HBC_ASSERT_NEXT(a_wb_hold, st_r == E_WB && !res_ready, st_r == E_WB && $stable(cnt_new_r) && $stable(slot_r), "write-back changed while stalled")
  `HBC_ASSERT_NOW(a_full_no_write, st_r == E_WB && full_r, !pair_we && !row_we && cnt_new_r == '0, "store written for an uncounted pair")

endmodule

// File: hw/rtl/hangul_bigram_counter.sv
// Path of a pair: decoder queue, hash, a read and a check per probe, write-back, output
// register; a non power-of-two PAIR_SLOTS adds the hash's quotient and remainder states.
// Throughput: one byte per cycle with no pair; otherwise one pair at a time, set by the
// hash, the read/check loop on the pair RAM port and the write-back.
// Reset: synchronous, active low; afterwards a clearing pass over max(PAIR_SLOTS, 11173)
// addresses zeroes both stores, with in_tready low until it is done.
module hangul_bigram_counter #(
  parameter int PAIR_SLOTS = 65536,
  parameter int MAX_PROBE  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  // pair results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [15:0] from_code, [31:16] to_code,
                                  // [63:32] pair_count, [95:64] row_total
  output logic [0:0]  out_tuser,  // [0] store_full
  output logic        out_tlast   // last_of_run
);
  import hbc_pkg::*;

  logic      dec_enable;
  logic      req_valid, req_ready;
  pair_req_t req;
  logic      clearing;
  logic      res_valid, res_ready;
  result_t   res;

  logic      out_valid_r;
  result_t   out_res_r;

  // Byte decoder: one transaction per cycle into it after clearing, while no pair is queued.
  // Each byte leaves 0, 1 or 2 pair requests; the queue drains into the engine.
  assign dec_enable = !clearing;

  hbc_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .enable      (dec_enable),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .req_valid   (req_valid),
    .req         (req),
    .req_ready   (req_ready)
  );

  // Engine owns both RAMs; one pair in flight, so a write-back always
  // lands before the next pair's first read (no same-entry overlap).
  hbc_probe #(
    .PAIR_SLOTS (PAIR_SLOTS),
    .MAX_PROBE  (MAX_PROBE),
    .COUNT_BITS (COUNT_BITS)
  ) u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: decouples the engine from a stalled consumer, so the
  // next pair can hash and probe while this result waits.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_res_r.row_total, out_res_r.pair_count,
                         out_res_r.to_code, out_res_r.from_code};
  assign out_tuser[0] = out_res_r.store_full;
  assign out_tlast    = out_res_r.last_of_run;

endmodule

// File: bench/hangul_bigram_counter_test.sv
// Self-checking bench for hangul_bigram_counter: UTF-8 byte stream in, bigram tallies out.
// Needs hbc_pkg and the hangul_bigram_counter RTL; the scoreboard class holds its own
// copy of the decoder, the hashed pair store and the row totals.
`timescale 1ns / 100ps

import hbc_pkg::*;

class bigram_scoreboard;
  // Store geometry of the default build; slot indexes wrap at 16 bits.
  localparam int PAIR_SLOTS = 65536;
  localparam int MAX_PROBE = 16;
  localparam bit [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // UTF-8 decoder and open word
  bit [1:0] bytes_left;
  bit [CP_W-1:0] cp_acc;
  bit word_open;
  bit [SYM_W-1:0] prev_syl;

  // counting stores, cleared like the block after reset
  bit [31:0] row_sum [ROW_DEPTH];
  bit slot_used [PAIR_SLOTS];
  bit [SYM_W-1:0] slot_fi [PAIR_SLOTS];
  bit [SYM_W-1:0] slot_ti [PAIR_SLOTS];
  bit [31:0] slot_cnt [PAIR_SLOTS];

  result_t expected_pairs[$];
  int mismatches;

  // Home slot of a pair: multiplicative hash of the pair key, low 16 bits.
  function bit [15:0] slot_hash(bit [SYM_W-1:0] fi, bit [SYM_W-1:0] ti);
    bit [63:0] key;
    bit [63:0] prod;
    key = 64'(fi) * 64'(ROW_DEPTH) + 64'(ti);
    prod = key * 64'(HASH_MUL);
    return prod[15:0];
  endfunction

  // Linear probe, then bump pair count and row total, or flag the store as full.
  function void tally_pair(bit [SYM_W-1:0] fi, bit [SYM_W-1:0] ti);
    bit [15:0] slot;
    bit hit;
    result_t r;
    hit = 1'b0;
    slot = slot_hash(fi, ti);
    for (int k = 0; k < MAX_PROBE; k++) begin
      if (!slot_used[slot]) begin
        slot_used[slot] = 1'b1;
        slot_fi[slot] = fi;
        slot_ti[slot] = ti;
        slot_cnt[slot] = '0;
        hit = 1'b1;
        break;
      end
      if (slot_fi[slot] == fi && slot_ti[slot] == ti) begin
        hit = 1'b1;
        break;
      end
      slot = slot + 16'd1;
    end
    r.from_code = (fi == 0) ? MARK_BEGIN : SYL_BASE + 16'(fi) - 16'd1;
    r.to_code = (ti == 0) ? MARK_END : SYL_BASE + 16'(ti) - 16'd1;
    r.last_of_run = 1'b0;
    if (hit) begin
      if (slot_cnt[slot] != COUNT_MAX) slot_cnt[slot]++;
      if (row_sum[fi] != COUNT_MAX) row_sum[fi]++;
      r.pair_count = slot_cnt[slot];
      r.row_total = row_sum[fi];
      r.store_full = 1'b0;
    end else begin
      r.pair_count = '0;
      r.row_total = row_sum[fi];
      r.store_full = 1'b1;
    end
    expected_pairs.push_back(r);
  endfunction

  // A syllable extends the word; anything else closes it with the end marker.
  function void close_or_extend(bit [CP_W-1:0] cp);
    bit [SYM_W-1:0] off;
    if (cp >= CP_W'(SYL_BASE) && cp <= CP_W'(SYL_LAST)) begin
      off = SYM_W'(cp - CP_W'(SYL_BASE));
      tally_pair(word_open ? prev_syl + 1'b1 : '0, off + 1'b1);
      prev_syl = off;
      word_open = 1'b1;
    end else begin
      if (word_open) tally_pair(prev_syl + 1'b1, '0);
      word_open = 1'b0;
    end
  endfunction

  function void note_byte(bit [7:0] b, bit eot);
    int n_prior;
    result_t r;
    n_prior = expected_pairs.size();
    if (bytes_left != 0) begin
      // continuation: top bits are not checked
      cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
      bytes_left--;
      if (bytes_left == 0) close_or_extend(cp_acc);
    end else if (b < 8'h80) begin
      close_or_extend(CP_W'(b));
    end else if ((b & LEAD2_MASK) == LEAD2) begin
      cp_acc = CP_W'(b[4:0]);
      bytes_left = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3) begin
      cp_acc = CP_W'(b[3:0]);
      bytes_left = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4) begin
      cp_acc = CP_W'(b[2:0]);
      bytes_left = 2'd3;
    end else begin
      // stray continuation or 11111xxx: one non-Hangul symbol
      close_or_extend('1);
    end
    if (eot) begin
      bytes_left = '0;
      cp_acc = '0;
      if (word_open) tally_pair(prev_syl + 1'b1, '0);
      word_open = 1'b0;
    end
    if (expected_pairs.size() > n_prior) begin
      r = expected_pairs.pop_back();
      r.last_of_run = 1'b1;
      expected_pairs.push_back(r);
    end
  endfunction

  function void check_field(string name, bit [31:0] want, bit [31:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_pairs.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h -> %0h", $time,
               got.from_code, got.to_code);
      mismatches++;
      return;
    end
    want = expected_pairs.pop_front();
    check_field("from_code", want.from_code, got.from_code);
    check_field("to_code", want.to_code, got.to_code);
    check_field("pair_count", want.pair_count, got.pair_count);
    check_field("row_total", want.row_total, got.row_total);
    check_field("store_full", want.store_full, got.store_full);
    check_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction

  function int pairs_outstanding();
    return expected_pairs.size();
  endfunction
endclass

module hangul_bigram_counter_test;
  // A slow correct run, including the clearing pass after reset, heavy
  // stalls and long probes, stays well below this limit.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_BYTES = 620;      // bytes per idling phase
  localparam int TOTAL_BYTES = 3 * PHASE_BYTES;
  localparam int FULL_PAIRS = 20;        // colliding pairs sent to overflow one probe window

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;

  int send_idle_pct = 14;
  int recv_stall_pct = 57;
  int bytes_sent;
  longint cycle_count;
  bit [SYM_W-1:0] common_syl [12];

  bigram_scoreboard sb = new();

  hangul_bigram_counter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side backpressure, redrawn every cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Transaction monitor: inputs feed the predictor, results get checked.
  // Runs in the active region of the rising edge, so it sees pre-edge values.
  always @(posedge clk) begin : monitor
    result_t seen;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pairs_outstanding());
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen.from_code = out_tdata[15:0];
        seen.to_code = out_tdata[31:16];
        seen.pair_count = out_tdata[63:32];
        seen.row_total = out_tdata[95:64];
        seen.store_full = out_tuser[0];
        seen.last_of_run = out_tlast;
        sb.check_result(seen);
      end
    end
  end

  // Present one byte at a falling edge, hold it until the handshake completes.
  task automatic send_byte(input bit [7:0] b, input bit eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hangul syllable as three UTF-8 bytes; eot rides on the last byte.
  task automatic send_syllable(input bit [SYM_W-1:0] off, input bit eot);
    bit [15:0] cp;
    cp = SYL_BASE + 16'(off);
    send_byte({4'b1110, cp[15:12]}, 1'b0);
    send_byte({2'b10, cp[11:6]}, 1'b0);
    send_byte({2'b10, cp[5:0]}, eot);
  endtask

  function automatic bit rand_eot();
    return $urandom_range(99) < 2;
  endfunction

  // Continuation byte, now and then with broken top bits (the decoder ignores them).
  function automatic bit [7:0] cont_byte();
    return ($urandom_range(99) < 25) ? 8'($urandom) : {2'b10, 6'($urandom)};
  endfunction

  // Mostly well-formed Hangul text over a small alphabet so pairs repeat,
  // mixed with ASCII, other scripts, noise and cut-off sequences.
  task automatic send_random_token();
    int pick;
    bit [SYM_W-1:0] off;
    pick = $urandom_range(99);
    if (pick < 55) begin
      off = ($urandom_range(99) < 70) ? common_syl[$urandom_range(11)]
                                      : SYM_W'($urandom_range(11171));
      send_syllable(off, rand_eot());
    end else if (pick < 70) begin
      send_byte(8'($urandom_range(127)), rand_eot());
    end else if (pick < 77) begin
      send_byte({3'b110, 5'($urandom)}, 1'b0);
      send_byte(cont_byte(), rand_eot());
    end else if (pick < 82) begin
      send_byte({5'b11110, 3'($urandom)}, 1'b0);
      send_byte(cont_byte(), 1'b0);
      send_byte(cont_byte(), 1'b0);
      send_byte(cont_byte(), rand_eot());
    end else if (pick < 88) begin
      send_byte({4'b1110, 4'($urandom)}, 1'b0);
      send_byte(cont_byte(), 1'b0);
      send_byte(cont_byte(), rand_eot());
    end else if (pick < 95) begin
      send_byte(8'($urandom), rand_eot());
    end else begin
      // cut-off sequence: either dropped by eot or it swallows the next bytes
      send_byte({4'b1110, 4'($urandom)}, 1'b0);
      send_byte(cont_byte(), 1'($urandom_range(1)));
    end
  endtask

  // Words of two syllables whose pair keys all hash into one 4-slot window,
  // so the probe run fills up and the later pairs find no slot.
  task automatic overflow_probe_window();
    bit [SYM_W-1:0] hit_fi [$];
    bit [SYM_W-1:0] hit_ti [$];
    bit [15:0] home;
    home = sb.slot_hash(14'd1, 14'd1);
    for (int fi = 1; fi <= 11172 && hit_fi.size() < FULL_PAIRS; fi++) begin
      for (int ti = 1; ti <= 11172 && hit_fi.size() < FULL_PAIRS; ti++) begin
        if (16'(sb.slot_hash(SYM_W'(fi), SYM_W'(ti)) - home) < 16'd4) begin
          hit_fi.push_back(SYM_W'(fi));
          hit_ti.push_back(SYM_W'(ti));
        end
      end
    end
    // last pair twice: it stays uncounted once the window is full
    hit_fi.push_back(hit_fi[$]);
    hit_ti.push_back(hit_ti[$]);
    foreach (hit_fi[i]) begin
      send_syllable(hit_fi[i] - 1'b1, 1'b0);
      send_syllable(hit_ti[i] - 1'b1, 1'b0);
      send_byte(8'h20, 1'b0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    foreach (common_syl[i]) common_syl[i] = SYM_W'($urandom_range(11171));
    common_syl[0] = '0;
    common_syl[1] = SYM_W'(11171);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    send_byte(8'h00, 1'b0);               // ASCII with no word open: no pair
    send_syllable(14'd0, 1'b0);           // first syllable opens a word
    send_syllable(14'd11171, 1'b0);       // last syllable
    send_byte(8'h7F, 1'b0);               // ASCII closes with end marker
    send_byte(8'hF0, 1'b0);               // overlong 4-byte form of U+AC00
    send_byte(8'h8A, 1'b0);
    send_byte(8'hB0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEA, 1'b0);               // U+AC01 with bad continuation top bits
    send_byte(8'hF0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);               // invalid lead closes the word
    send_byte(8'hC3, 1'b0);               // two-byte non-Hangul, no word open
    send_byte(8'hA9, 1'b0);
    send_byte(8'h80, 1'b0);               // stray continuation as lead
    send_byte(8'hF8, 1'b0);
    send_syllable(14'd1024, 1'b1);        // one-syllable word closed by eot
    send_syllable(14'd0, 1'b0);
    send_byte(8'hEA, 1'b0);               // truncated sequence dropped at eot
    send_byte(8'hB0, 1'b1);
    send_byte(8'h20, 1'b1);               // eot with nothing open

    overflow_probe_window();

    // --- random, three idling phases ---
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= 2 * PHASE_BYTES) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (bytes_sent >= PHASE_BYTES) begin
        send_idle_pct = 57;
        recv_stall_pct = 14;
      end
      send_random_token();
    end
    in_tvalid <= 1'b0;

    // drain, then leave room for any stray result to show up
    while (sb.pairs_outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
